### hdl/assert_macros.svh
// assertion helpers used by the decoder datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/rbd_pkg.sv
package rbd_pkg;

	// field widths fixed by the stream format
	localparam int BYTE_W     = 8;
	localparam int COUNT_W    = 6;
	localparam int CAP_W      = 24;
	localparam int REPEAT_BIT = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 24'hFFFFFF;

	// result kinds
	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_DONE     = 2'd1,
		KIND_OVERFLOW = 2'd2
	} kind_t;

	// what the next input byte means
	typedef enum logic [1:0] {
		MODE_HEADER  = 2'd0,
		MODE_REPEAT  = 2'd1,
		MODE_LITERAL = 2'd2,
		MODE_DROP    = 2'd3
	} mode_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic emit_run;
		logic emit_done;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic acc_run;
		logic acc_done;
		logic run_last;
		logic fend_q;
		logic out_free;
	} sts_t;

endpackage

### hdl/rbd_ctrl.sv
module rbd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  rbd_pkg::sts_t sts,
	output rbd_pkg::cmd_t cmd
);
	import rbd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// input is taken only when idle and the output word can move
	assign in_stall = !((state_q == ST_IDLE) && sts.out_free);

	// command decode and next state
	always_comb begin
		state_d       = state_q;
		cmd.accept    = 1'b0;
		cmd.emit_run  = 1'b0;
		cmd.emit_done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.out_free) begin
					cmd.accept = 1'b1;
					if (sts.acc_run) begin
						state_d = ST_RUN;
					end else if (sts.acc_done) begin
						state_d = ST_DONE;
					end
				end
			end
			ST_RUN: begin
				if (sts.out_free) begin
					cmd.emit_run = 1'b1;
					if (sts.run_last) begin
						state_d = sts.fend_q ? ST_DONE : ST_IDLE;
					end
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit_done = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hdl/rbd_datapath.sv
`include "assert_macros.svh"

module rbd_datapath #(
	parameter int TOTAL_WIDTH = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rbd_pkg::cmd_t             cmd,
	output rbd_pkg::sts_t             sts,
	input  logic [rbd_pkg::BYTE_W-1:0] in_byte,
	input  logic                      frame_end,
	input  logic                      cfg_valid,
	input  logic [rbd_pkg::CAP_W-1:0] cfg_data,
	input  logic                      out_stall,
	output logic                      out_valid,
	output logic [1:0]                kind,
	output logic [rbd_pkg::BYTE_W-1:0] value,
	output logic [TOTAL_WIDTH-1:0]    total_size,
	output logic                      last
);
	import rbd_pkg::*;

	// compare width covers both the register and the running total
	localparam int CW = (TOTAL_WIDTH > CAP_W) ? TOTAL_WIDTH : CAP_W;
	localparam logic [CW-1:0] TOTAL_MAX = CW'((64'd1 << TOTAL_WIDTH) - 64'd1);

	logic [CAP_W-1:0]       cap_q;
	mode_t                  mode_q, mode_d;
	logic [COUNT_W-1:0]     rep_q, rep_d;
	logic [COUNT_W-1:0]     lit_q, lit_d;
	logic [TOTAL_WIDTH-1:0] total_q, total_d;
	logic [BYTE_W-1:0]      val_q, val_d;
	logic                   fend_q;
	logic                   ov_q;
	kind_t                  kind_q;
	logic [BYTE_W-1:0]      value_q;
	logic [TOTAL_WIDTH-1:0] size_q;
	logic                   last_q;

	logic                   ld;
	kind_t                  ld_kind;
	logic [BYTE_W-1:0]      ld_value;
	logic [TOTAL_WIDTH-1:0] ld_size;
	logic                   ld_last;
	logic                   clr;

	logic [COUNT_W-1:0]     count;
	logic [CW-1:0]          cap_ext;
	logic [CW-1:0]          limit;
	logic [CW:0]            sum;
	logic                   ovf;

	// header capacity check
	assign count   = in_byte[COUNT_W-1:0];
	assign cap_ext = CW'(cap_q);
	assign limit   = (cap_ext > TOTAL_MAX) ? TOTAL_MAX : cap_ext;
	assign sum     = (CW+1)'(total_q) + (CW+1)'(count);
	assign ovf     = sum > {1'b0, limit};

	// status to the controller
	assign sts.acc_run  = (mode_q == MODE_REPEAT) && (rep_q != '0);
	assign sts.acc_done = (mode_q == MODE_LITERAL) && frame_end;
	assign sts.run_last = (rep_q == COUNT_W'(1));
	assign sts.fend_q   = fend_q;
	assign sts.out_free = !ov_q || !out_stall;

	// decode step
	always_comb begin
		mode_d   = mode_q;
		rep_d    = rep_q;
		lit_d    = lit_q;
		total_d  = total_q;
		val_d    = val_q;
		ld       = 1'b0;
		ld_kind  = KIND_DATA;
		ld_value = '0;
		ld_size  = total_q;
		ld_last  = 1'b0;
		clr      = 1'b0;
		if (cmd.accept) begin
			case (mode_q)
				MODE_HEADER: begin
					if (ovf) begin
						ld      = 1'b1;
						ld_kind = KIND_OVERFLOW;
						ld_last = 1'b1;
						if (frame_end) begin
							clr = 1'b1;
						end else begin
							mode_d = MODE_DROP;
						end
					end else if (frame_end) begin
						ld      = 1'b1;
						ld_kind = KIND_DONE;
						ld_last = 1'b1;
						clr     = 1'b1;
					end else if (in_byte[REPEAT_BIT]) begin
						rep_d  = count;
						mode_d = MODE_REPEAT;
					end else if (count != '0) begin
						lit_d  = count;
						mode_d = MODE_LITERAL;
					end
				end
				MODE_REPEAT: begin
					val_d = in_byte;
					if (rep_q == '0) begin
						mode_d = MODE_HEADER;
						if (frame_end) begin
							ld      = 1'b1;
							ld_kind = KIND_DONE;
							ld_last = 1'b1;
							clr     = 1'b1;
						end
					end
				end
				MODE_LITERAL: begin
					total_d  = total_q + TOTAL_WIDTH'(1);
					ld       = 1'b1;
					ld_value = in_byte;
					ld_size  = total_d;
					ld_last  = !frame_end;
					lit_d    = lit_q - COUNT_W'(1);
					if (lit_q == COUNT_W'(1)) begin
						mode_d = MODE_HEADER;
					end
				end
				MODE_DROP: begin
					if (frame_end) begin
						clr = 1'b1;
					end
				end
				default: begin
					clr = 1'b1;
				end
			endcase
		end else if (cmd.emit_run) begin
			total_d  = total_q + TOTAL_WIDTH'(1);
			ld       = 1'b1;
			ld_value = val_q;
			ld_size  = total_d;
			ld_last  = (rep_q == COUNT_W'(1)) && !fend_q;
			rep_d    = rep_q - COUNT_W'(1);
			if (rep_q == COUNT_W'(1)) begin
				mode_d = MODE_HEADER;
			end
		end else if (cmd.emit_done) begin
			ld      = 1'b1;
			ld_kind = KIND_DONE;
			ld_last = 1'b1;
			clr     = 1'b1;
		end
		if (clr) begin
			mode_d  = MODE_HEADER;
			rep_d   = '0;
			lit_d   = '0;
			total_d = '0;
		end
	end

	// frame state, capacity register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			mode_q  <= MODE_HEADER;
			rep_q   <= '0;
			lit_q   <= '0;
			total_q <= '0;
			fend_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			mode_q  <= mode_d;
			rep_q   <= rep_d;
			lit_q   <= lit_d;
			total_q <= total_d;
			if (cmd.accept) begin
				fend_q <= frame_end;
			end
			if (ld) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	// output word and held value byte
	always_ff @(posedge clk) begin
		val_q <= val_d;
		if (ld) begin
			kind_q  <= ld_kind;
			value_q <= ld_value;
			size_q  <= ld_size;
			last_q  <= ld_last;
		end
	end

	assign out_valid  = ov_q;
	assign kind       = kind_q;
	assign value      = value_q;
	assign total_size = size_q;
	assign last       = last_q;

	`ASSERT_IMPLIES(a_load_free, clk, arst_n, ld, (!ov_q || !out_stall), "word overwritten while stalled")
	`ASSERT_NEXT(a_done_clears, clk, arst_n, cmd.emit_done, (total_q == '0 && mode_q == MODE_HEADER), "frame state not cleared after done")
	`ASSERT_IMPLIES(a_run_count, clk, arst_n, cmd.emit_run, (rep_q != '0 && mode_q == MODE_REPEAT), "repeat emitted with no count left")

endmodule

### hdl/rle_byte_run_decoder_unit.sv
// Run-length decoder, one encoded byte per input word.
// Input channel: in_valid / in_stall with in_byte and frame_end (last byte of a frame).
// Output channel: out_valid / out_stall with kind, value, total_size and last;
// last marks the final result caused by one input byte.
// Config channel: cfg_valid / cfg_ready with cfg_data, the per-frame output capacity;
// cfg_ready is always high, write it only while the decoder is idle.
// The word caused by a header or literal byte is valid in the cycle after its
// accept; the repeat words of a value byte are loaded from the run state after
// its accept, whenever the output word can move. A literal byte that ends the
// frame holds the input until the done word is loaded; a repeat value byte holds
// the input until all its repeat words (and the done word, when it ends the frame)
// are loaded, since every result passes through the single output register.
// When out_stall is high the output word holds, and the input is stalled for
// as long as a stalled word sits in the output register.
// Reset clears the frame state, empties the output register and sets the
// capacity to its maximum.
module rle_byte_run_decoder_unit #(
	parameter int TOTAL_WIDTH = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [rbd_pkg::BYTE_W-1:0] in_byte,
	input  logic                       frame_end,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 kind,
	output logic [rbd_pkg::BYTE_W-1:0] value,
	output logic [TOTAL_WIDTH-1:0]     total_size,
	output logic                       last,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [rbd_pkg::CAP_W-1:0]  cfg_data
);
	import rbd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// capacity register accepts writes at any time
	assign cfg_ready = 1'b1;

	// sequencing of accepts, repeat emission and done words
	rbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// frame state, capacity check and output register
	rbd_datapath #(
		.TOTAL_WIDTH (TOTAL_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_byte    (in_byte),
		.frame_end  (frame_end),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.kind       (kind),
		.value      (value),
		.total_size (total_size),
		.last       (last)
	);

endmodule
